FILE: design/c3s_pkg.sv
// c3s_pkg: widths, payload types and saturation constants for the 3x3 solver
// no dependencies; imported by every module of the block
package c3s_pkg;

	// input coefficient width, signed fixed point; the fraction scale cancels in the ratios
	localparam int COEF_WIDTH = 16;
	// matrix entry: coefficient widened by one bit so a negated constant is exact
	localparam int EW = COEF_WIDTH + 1;
	// 2x2 product, 2x2 minor, first column term, full determinant
	localparam int PW = 2 * EW;
	localparam int MW = PW + 1;
	localparam int TW = EW + MW;
	localparam int DW = TW + 2;

	// result format: signed Q16.16
	localparam int QW = 32;
	localparam int OUT_FRAC = 16;
	localparam int IPW = QW - OUT_FRAC;

	// queue between determinant front and divider back, power of two
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

	typedef logic signed [COEF_WIDTH-1:0] coef_t;
	typedef logic signed [QW-1:0] val_t;
	typedef logic signed [DW-1:0] det_t;

	typedef struct packed {
		coef_t x_coef_eq1;
		coef_t x_coef_eq2;
		coef_t x_coef_eq3;
		coef_t y_coef_eq1;
		coef_t y_coef_eq2;
		coef_t y_coef_eq3;
		coef_t z_coef_eq1;
		coef_t z_coef_eq2;
		coef_t z_coef_eq3;
		coef_t const_eq1;
		coef_t const_eq2;
		coef_t const_eq3;
	} in_item_t;

	typedef struct packed {
		val_t x_value;
		val_t y_value;
		val_t z_value;
		logic singular;
	} out_item_t;

	// main determinant and the three numerators
	typedef struct packed {
		det_t dmain;
		det_t dx;
		det_t dy;
		det_t dz;
	} dets_t;

	// handshake between queue and back end
	typedef struct packed {
		logic avail;
		logic can_push;
	} q_stat_t;

endpackage

FILE: design/c3s_front.sv
// c3s_front: five-stage pipeline computing the four 3x3 determinants
// depends on c3s_pkg
module c3s_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  c3s_pkg::in_item_t in_item,
	output logic             out_valid,
	output c3s_pkg::dets_t   dets
);
	import c3s_pkg::*;

	typedef logic signed [EW-1:0] ent_t;

	ent_t m_s1 [3][3];
	ent_t nd_s1 [3];
	ent_t w [4][3][3];
	logic signed [PW-1:0] p_s2 [4][6];
	ent_t c0_s2 [4][3];
	logic signed [MW-1:0] t_s3 [4][3];
	ent_t c0_s3 [4][3];
	logic signed [TW-1:0] u_s4 [4][3];
	det_t d_s5 [4];
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// widen coefficients, negate constants
	always_ff @(posedge clk) begin
		if (en) begin
			m_s1[0][0] <= ent_t'(in_item.x_coef_eq1);
			m_s1[1][0] <= ent_t'(in_item.x_coef_eq2);
			m_s1[2][0] <= ent_t'(in_item.x_coef_eq3);
			m_s1[0][1] <= ent_t'(in_item.y_coef_eq1);
			m_s1[1][1] <= ent_t'(in_item.y_coef_eq2);
			m_s1[2][1] <= ent_t'(in_item.y_coef_eq3);
			m_s1[0][2] <= ent_t'(in_item.z_coef_eq1);
			m_s1[1][2] <= ent_t'(in_item.z_coef_eq2);
			m_s1[2][2] <= ent_t'(in_item.z_coef_eq3);
			nd_s1[0] <= ent_t'(0) - ent_t'(in_item.const_eq1);
			nd_s1[1] <= ent_t'(0) - ent_t'(in_item.const_eq2);
			nd_s1[2] <= ent_t'(0) - ent_t'(in_item.const_eq3);
		end
	end

	// matrix k: main for k 0, else column k-1 replaced by negated constants
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					w[k][r][c] = (k != 0 && c == k - 1) ? nd_s1[r] : m_s1[r][c];
				end
			end
		end
	end

	// minor products, first column carried along
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				p_s2[k][0] <= w[k][1][1] * w[k][2][2];
				p_s2[k][1] <= w[k][1][2] * w[k][2][1];
				p_s2[k][2] <= w[k][0][1] * w[k][2][2];
				p_s2[k][3] <= w[k][0][2] * w[k][2][1];
				p_s2[k][4] <= w[k][0][1] * w[k][1][2];
				p_s2[k][5] <= w[k][0][2] * w[k][1][1];
				for (int r = 0; r < 3; r++) begin
					c0_s2[k][r] <= w[k][r][0];
				end
			end
		end
	end

	// 2x2 minors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				for (int j = 0; j < 3; j++) begin
					t_s3[k][j] <= MW'(p_s2[k][2*j]) - MW'(p_s2[k][2*j+1]);
					c0_s3[k][j] <= c0_s2[k][j];
				end
			end
		end
	end

	// first column times cofactor
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				for (int j = 0; j < 3; j++) begin
					u_s4[k][j] <= TW'(c0_s3[k][j]) * TW'(t_s3[k][j]);
				end
			end
		end
	end

	// expansion along the first column
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				d_s5[k] <= DW'(u_s4[k][0]) - DW'(u_s4[k][1]) + DW'(u_s4[k][2]);
			end
		end
	end

	assign out_valid  = v_s5;
	assign dets.dmain = d_s5[0];
	assign dets.dx    = d_s5[1];
	assign dets.dy    = d_s5[2];
	assign dets.dz    = d_s5[3];

endmodule

FILE: design/c3s_queue.sv
// c3s_queue: small fifo of determinant sets between front and back
// depends on c3s_pkg
module c3s_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  c3s_pkg::dets_t    push_data,
	input  logic              pop,
	output c3s_pkg::q_stat_t  stat,
	output c3s_pkg::dets_t    head
);
	import c3s_pkg::*;

	dets_t mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0] cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	assign head          = mem_q[rd_ptr_q];
	assign stat.avail    = (cnt_q != '0);
	assign stat.can_push = (cnt_q != (QAW+1)'(QDEPTH)) || pop;

endmodule

FILE: design/c3s_back.sv
// c3s_back: three pipelined restoring dividers, one quotient bit per stage,
// then saturation and the output register; depends on c3s_pkg
module c3s_back (
	input  logic               clk,
	input  logic               arst_n,
	input  c3s_pkg::q_stat_t   qstat,
	input  c3s_pkg::dets_t     head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output c3s_pkg::out_item_t out_item
);
	import c3s_pkg::*;

	typedef logic [DW-1:0] mag_t;

	typedef struct packed {
		mag_t r;
		logic [QW-1:0] sh;
		logic [QW-1:0] q;
		mag_t d;
		logic neg;
		logic ovf;
	} lane_t;

	logic en;
	det_t num [3];
	mag_t n_s1 [3];
	mag_t d_s1;
	logic neg_s1 [3];
	logic sg_s1, v_s1;
	lane_t dv_s [QW+1][3];
	logic dsg_s [QW+1];
	logic dv_v [QW+1];
	lane_t nx [QW][3];
	logic [DW:0] r2 [QW][3];
	logic ge [QW][3];
	out_item_t out_q;
	logic out_v_q;
	val_t res [3];

	assign en  = !(out_v_q && out_stall);
	assign pop = en && qstat.avail;

	assign num[0] = head.dx;
	assign num[1] = head.dy;
	assign num[2] = head.dz;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i <= QW; i++) dv_v[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= qstat.avail;
			dv_v[0] <= v_s1;
			for (int i = 0; i < QW; i++) dv_v[i+1] <= dv_v[i];
			out_v_q <= dv_v[QW];
		end
	end

	// signs and magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= mag_t'(head.dmain[DW-1] ? -head.dmain : head.dmain);
			sg_s1 <= (head.dmain == '0);
			for (int l = 0; l < 3; l++) begin
				n_s1[l]   <= mag_t'(num[l][DW-1] ? -num[l] : num[l]);
				neg_s1[l] <= num[l][DW-1] ^ head.dmain[DW-1];
			end
		end
	end

	// one restoring step per stage and lane
	always_comb begin
		for (int i = 0; i < QW; i++) begin
			for (int l = 0; l < 3; l++) begin
				r2[i][l] = {dv_s[i][l].r, dv_s[i][l].sh[QW-1]};
				ge[i][l] = r2[i][l] >= {1'b0, dv_s[i][l].d};
				nx[i][l] = dv_s[i][l];
				nx[i][l].r  = ge[i][l] ? mag_t'(r2[i][l] - {1'b0, dv_s[i][l].d})
				                       : mag_t'(r2[i][l]);
				nx[i][l].sh = {dv_s[i][l].sh[QW-2:0], 1'b0};
				nx[i][l].q  = {dv_s[i][l].q[QW-2:0], ge[i][l]};
			end
		end
	end

	// overflow check and first partial remainder, then the divider stages
	always_ff @(posedge clk) begin
		if (en) begin
			dsg_s[0] <= sg_s1;
			for (int l = 0; l < 3; l++) begin
				dv_s[0][l].ovf <= {{IPW{1'b0}}, n_s1[l]} >= {d_s1, {IPW{1'b0}}};
				dv_s[0][l].r   <= n_s1[l] >> IPW;
				dv_s[0][l].sh  <= {n_s1[l][IPW-1:0], {OUT_FRAC{1'b0}}};
				dv_s[0][l].q   <= '0;
				dv_s[0][l].d   <= d_s1;
				dv_s[0][l].neg <= neg_s1[l];
			end
			for (int i = 0; i < QW; i++) begin
				dsg_s[i+1] <= dsg_s[i];
				for (int l = 0; l < 3; l++) dv_s[i+1][l] <= nx[i][l];
			end
		end
	end

	// sign and saturation
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (dv_s[QW][l].neg) begin
				res[l] = (dv_s[QW][l].ovf || dv_s[QW][l].q > SAT_NEG) ? val_t'(SAT_NEG)
				                                                      : val_t'(-dv_s[QW][l].q);
			end else begin
				res[l] = (dv_s[QW][l].ovf || dv_s[QW][l].q[QW-1]) ? val_t'(SAT_POS)
				                                                   : val_t'(dv_s[QW][l].q);
			end
		end
	end

	// output register, singular forces zero values
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.singular <= dsg_s[QW];
			out_q.x_value  <= dsg_s[QW] ? '0 : res[0];
			out_q.y_value  <= dsg_s[QW] ? '0 : res[1];
			out_q.z_value  <= dsg_s[QW] ? '0 : res[2];
		end
	end

	assign out_valid = out_v_q;
	assign out_item  = out_q;

endmodule

FILE: design/cramer_3x3_solver.sv
// cramer_3x3_solver: top level, Cramer's rule solver for 3x3 linear systems
// depends on c3s_pkg, c3s_front, c3s_queue, c3s_back
//
//  channel | signals                       | direction
//  eqn     | eqn_valid, eqn_stall, eqn     | coefficient set in, stall out
//  sol     | sol_valid, sol_stall, sol     | solution out, stall in
//
// one item per cycle sustained while sol is not stalled; from accept to result
// valid an item passes the 5-stage determinant pipeline, queue write, 2 setup
// stages, the 32-stage bit-per-stage dividers and the output register
// reset clears the valid chains and the queue counters only
// a stall at sol with a valid result freezes the divider back end; the front
// keeps going until the queue between them fills, then eqn_stall rises
module cramer_3x3_solver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               eqn_valid,
	output logic               eqn_stall,
	input  c3s_pkg::in_item_t  eqn,
	output logic               sol_valid,
	input  logic               sol_stall,
	output c3s_pkg::out_item_t sol
);
	import c3s_pkg::*;

	logic f_valid, push, pop;
	dets_t f_dets, q_head;
	q_stat_t qstat;

	assign eqn_stall = !qstat.can_push;
	assign push      = f_valid && qstat.can_push;

	c3s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (qstat.can_push),
		.in_valid  (eqn_valid),
		.in_item   (eqn),
		.out_valid (f_valid),
		.dets      (f_dets)
	);

	c3s_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (f_dets),
		.pop       (pop),
		.stat      (qstat),
		.head      (q_head)
	);

	c3s_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (q_head),
		.pop       (pop),
		.out_valid (sol_valid),
		.out_stall (sol_stall),
		.out_item  (sol)
	);

endmodule

FILE: design/c3s_check.sv
// c3s_check: port-level assertions for cramer_3x3_solver, bound to the top
// depends on c3s_pkg and cramer_3x3_solver
module c3s_check (
	input logic               clk,
	input logic               arst_n,
	input logic               eqn_valid,
	input logic               eqn_stall,
	input c3s_pkg::in_item_t  eqn,
	input logic               sol_valid,
	input logic               sol_stall,
	input c3s_pkg::out_item_t sol
);
	import c3s_pkg::*;

	// singular result carries zero values
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sol_valid && sol.singular |-> sol.x_value == '0 && sol.y_value == '0
			&& sol.z_value == '0)
		else $error("singular result with nonzero values");

	// no result while in reset
	a_rst_idle: assert property (@(posedge clk) !arst_n |-> !sol_valid)
		else $error("result valid during reset");

	// stalled result stays valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		sol_valid && sol_stall |=> sol_valid)
		else $error("result dropped under stall");

	// stalled result does not change
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		sol_valid && sol_stall |=> $stable(sol))
		else $error("result changed under stall");

endmodule

bind cramer_3x3_solver c3s_check u_c3s_check (.*);
